// File: hdl/graph_dfs_path_distance_macros.svh
// ----------------------------------------------------------------------------
// graph_dfs_path_distance assertion macros
// Implication checks on the block clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DFS_PATH_DISTANCE_MACROS_SVH
`define GRAPH_DFS_PATH_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define GDPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gdpd assertion failed");
// Next-cycle implication.
`define GDPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gdpd assertion failed");
`else
`define GDPD_ASSERT_IMP(lbl, ante, cons)
`define GDPD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hdl/gdpd_pkg.sv
// ----------------------------------------------------------------------------
// gdpd_pkg
// Types and codes shared by the graph search block and its parent-walk unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdpd_pkg;

	localparam int NODE_W = 4;
	localparam int DIST_W = 16;
	localparam int SUM_W  = 20;
	localparam int CMD_W  = 2;
	localparam int EV_W   = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	// Result event codes.
	localparam logic [EV_W-1:0] EV_PUSH    = 2'd0;
	localparam logic [EV_W-1:0] EV_POP     = 2'd1;
	localparam logic [EV_W-1:0] EV_SUMMARY = 2'd2;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [NODE_W-1:0] edge_source;
		logic [NODE_W-1:0] edge_dest;
		logic [DIST_W-1:0] edge_distance;
		logic [NODE_W-1:0] target_node;
	} in_item_t;

	typedef struct packed {
		logic [EV_W-1:0]   event_res;
		logic [NODE_W-1:0] node;
		logic              found;
		logic [SUM_W-1:0]  total_distance;
		logic              last;
	} out_item_t;

	// Parent table write and clear request.
	typedef struct packed {
		logic              clr;
		logic              en;
		logic [NODE_W-1:0] dest;
		logic [NODE_W-1:0] src;
		logic [DIST_W-1:0] weight;
	} par_wr_t;

	typedef struct packed {
		logic              go;
		logic [NODE_W-1:0] target;
	} walk_req_t;

	typedef struct packed {
		logic             done;
		logic             busy;
		logic [SUM_W-1:0] sum;
	} walk_rsp_t;

	typedef enum logic [1:0] {
		W_IDLE,
		W_READ,
		W_ADD
	} walk_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_TOP,
		S_CHECK,
		S_SCAN,
		S_WALK
	} srch_state_t;

endpackage

`default_nettype wire

// File: hdl/graph_dfs_path_distance.sv
// Clear and add-edge commands produce no result; a new command can be
// accepted in the next cycle.
// A search reports one push or pop per cycle at most. Each popped node takes a
// stack read, a compare and one edge-memory read per stored edge; the parent
// walk then reads and adds one table entry per step, for at most NODES steps.
// Reset clears counters, valid bits and the sequencer; no clearing pass runs.
// ----------------------------------------------------------------------------
// graph_dfs_path_distance
// Edge list loader and stack-based depth-first search with parent-chain
// distance summary, run by a small sequencer around one edge compare.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graph_dfs_path_distance_macros.svh"

module graph_dfs_path_distance #(
	parameter int NODES = 16,
	parameter int EDGES = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  gdpd_pkg::in_item_t  item,
	output gdpd_pkg::out_item_t result,
	output logic                result_strobe
);
	import gdpd_pkg::*;

	localparam int NIW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SDW = $clog2(NODES + 1);
	localparam int EIW = (EDGES > 1) ? $clog2(EDGES) : 1;
	localparam int ECW = $clog2(EDGES + 1);
	localparam int EW  = 2 * NODE_W;

	srch_state_t state_q, state_d;

	// Edge list memory and its scan pipeline.
	logic [EW-1:0]     edge_mem [EDGES];
	logic [ECW-1:0]    edge_cnt_q;
	logic [ECW-1:0]    scan_q;
	logic              rd_vld_s1;
	logic [NODE_W-1:0] from_s1, to_s1;

	// Node stack memory and visited marks.
	logic [NODE_W-1:0] stk_mem [NODES];
	logic [SDW-1:0]    depth_q;
	logic [NODE_W-1:0] top_s1;
	logic [NODES-1:0]  vis_q;

	logic [NODE_W-1:0] target_q;
	logic              found_q;
	out_item_t         res_q;
	logic              strobe_q;

	par_wr_t   par_wr;
	walk_req_t walk_req;
	walk_rsp_t walk_rsp;

	logic              accept, edge_ok, clr;
	logic              issue, do_push, do_pop, do_init, stk_re, set_found;
	logic              emit;
	logic [EV_W-1:0]   emit_ev;
	logic [NODE_W-1:0] emit_node;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = state_q != S_IDLE;
	assign clr     = accept && (item.command == CMD_CLEAR);
	assign edge_ok = accept && (item.command == CMD_ADD) && (edge_cnt_q < EDGES)
		&& (32'(item.edge_source) < NODES) && (32'(item.edge_dest) < NODES);
	assign issue   = (state_q == S_SCAN) && (scan_q < edge_cnt_q);

	// Edge compare: a matching edge to an unvisited node pushes it.
	assign do_push = (state_q == S_SCAN) && rd_vld_s1 && (from_s1 == top_s1)
		&& !vis_q[NIW'(to_s1)] && (depth_q < NODES);

	assign par_wr.clr    = clr;
	assign par_wr.en     = edge_ok;
	assign par_wr.dest   = item.edge_dest;
	assign par_wr.src    = item.edge_source;
	assign par_wr.weight = item.edge_distance;

	gdpd_parent_walk #(
		.NODES(NODES)
	) u_walk (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (par_wr),
		.req   (walk_req),
		.rsp   (walk_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and per-cycle controls.
	always_comb begin
		state_d         = state_q;
		do_pop          = 1'b0;
		do_init         = 1'b0;
		stk_re          = 1'b0;
		set_found       = 1'b0;
		walk_req.go     = 1'b0;
		walk_req.target = target_q;
		emit            = 1'b0;
		emit_ev         = EV_PUSH;
		emit_node       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && item.command == CMD_SEARCH) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				do_init = 1'b1;
				emit    = 1'b1;
				state_d = S_TOP;
			end
			S_TOP: begin
				if (depth_q == '0) begin
					walk_req.go = 1'b1;
					state_d     = S_WALK;
				end else begin
					stk_re  = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (top_s1 == target_q) begin
					set_found   = 1'b1;
					walk_req.go = 1'b1;
					state_d     = S_WALK;
				end else begin
					do_pop    = 1'b1;
					emit      = 1'b1;
					emit_ev   = EV_POP;
					emit_node = top_s1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (do_push) begin
					emit      = 1'b1;
					emit_node = to_s1;
				end
				if (!issue && !rd_vld_s1) begin
					state_d = S_TOP;
				end
			end
			S_WALK: begin
				if (walk_rsp.done) begin
					emit      = 1'b1;
					emit_ev   = EV_SUMMARY;
					emit_node = target_q;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memories and data registers without reset.
	always_ff @(posedge clk) begin
		if (edge_ok) begin
			edge_mem[edge_cnt_q[EIW-1:0]] <= {item.edge_source, item.edge_dest};
		end
		if (issue) begin
			{from_s1, to_s1} <= edge_mem[scan_q[EIW-1:0]];
		end
		if (do_init) begin
			stk_mem[0] <= '0;
		end else if (do_push) begin
			stk_mem[depth_q[NIW-1:0]] <= to_s1;
		end
		if (stk_re) begin
			top_s1 <= stk_mem[NIW'(depth_q - SDW'(1))];
		end
		if (accept) begin
			target_q <= item.target_node;
		end
		if (emit) begin
			res_q.event_res      <= emit_ev;
			res_q.node           <= emit_node;
			res_q.found          <= (emit_ev == EV_SUMMARY) && found_q;
			res_q.total_distance <= (emit_ev == EV_SUMMARY) ? walk_rsp.sum : '0;
			res_q.last           <= emit_ev == EV_SUMMARY;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
			depth_q    <= '0;
			vis_q      <= '0;
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q  <= emit;
			rd_vld_s1 <= issue;
			if (clr) begin
				edge_cnt_q <= '0;
				depth_q    <= '0;
				vis_q      <= '0;
			end else if (edge_ok) begin
				edge_cnt_q <= edge_cnt_q + ECW'(1);
			end
			// A new search starts with only the root marked.
			if (do_init) begin
				vis_q      <= NODES'(1);
				depth_q    <= SDW'(1);
				found_q    <= 1'b0;
			end
			if (do_pop) begin
				depth_q <= depth_q - SDW'(1);
				scan_q  <= '0;
			end
			if (issue) begin
				scan_q <= scan_q + ECW'(1);
			end
			if (do_push) begin
				depth_q              <= depth_q + SDW'(1);
				vis_q[NIW'(to_s1)] <= 1'b1;
			end
			if (set_found) begin
				found_q <= 1'b1;
			end
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

	// The stack never holds more than one entry per node.
	`GDPD_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= SDW'(NODES))
	// The block goes idle only together with the summary transfer.
	`GDPD_ASSERT_IMP(a_idle_with_summary, $fell(busy), result_strobe && result.last)
	// Push and pop transfers happen only inside a search.
	`GDPD_ASSERT_IMP(a_events_in_search, result_strobe && !result.last, busy)
	// The parent walk runs only while the sequencer waits for it.
	`GDPD_ASSERT_IMP(a_walk_owned, walk_rsp.busy, state_q == S_WALK)

endmodule

`default_nettype wire

// File: hdl/gdpd_parent_walk.sv
// ----------------------------------------------------------------------------
// gdpd_parent_walk
// Parent table (memory with per-entry valid bits) and the walk that sums
// parent distances from a node back toward the root, a read and an add per step.
// ----------------------------------------------------------------------------
`default_nettype none

module gdpd_parent_walk #(
	parameter int NODES = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  gdpd_pkg::par_wr_t   wr,
	input  gdpd_pkg::walk_req_t req,
	output gdpd_pkg::walk_rsp_t rsp
);
	import gdpd_pkg::*;

	localparam int NIW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SCW = $clog2(NODES + 1);
	localparam int PW  = NODE_W + DIST_W;

	logic [PW-1:0]    par_mem [NODES];
	logic [NODES-1:0] vld_q;
	logic [PW-1:0]    rd_s1;
	logic             rvld_s1;

	walk_state_t      state_q, state_d;
	logic [NIW-1:0]   cur_q;
	logic [SCW-1:0]   steps_q;
	logic [SUM_W-1:0] sum_q;
	logic             done_q;

	logic              tgt_ok;
	logic [DIST_W-1:0] step_dist;
	logic [NODE_W-1:0] step_par;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  sum_next;
	logic              walk_end;

	// Table storage: written on each accepted edge, read one entry per step.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			par_mem[NIW'(wr.dest)] <= {wr.src, wr.weight};
		end
		if (state_q == W_READ) begin
			rd_s1 <= par_mem[cur_q];
			rvld_s1 <= vld_q[cur_q];
		end
	end

	// An entry never written since reset or clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.clr) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[NIW'(wr.dest)] <= 1'b1;
		end
	end

	// One step: add the distance with saturation and decide whether to stop.
	always_comb begin
		tgt_ok    = 32'(req.target) < NODES;
		step_dist = rvld_s1 ? rd_s1[DIST_W-1:0] : '0;
		step_par  = rvld_s1 ? rd_s1[PW-1:DIST_W] : '0;
		sum_wide  = {1'b0, sum_q} + (SUM_W+1)'(step_dist);
		sum_next  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
		walk_end  = (step_par == '0) || (steps_q == SCW'(NODES - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			W_IDLE: begin
				if (req.go && tgt_ok) begin
					state_d = W_READ;
				end
			end
			W_READ: state_d = W_ADD;
			W_ADD: state_d = walk_end ? W_IDLE : W_READ;
			default: state_d = W_IDLE;
		endcase
	end

	// Walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			steps_q <= '0;
			sum_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == W_IDLE && req.go) begin
				cur_q   <= NIW'(req.target);
				steps_q <= '0;
				sum_q   <= '0;
				done_q  <= !tgt_ok;
			end else if (state_q == W_ADD) begin
				sum_q   <= sum_next;
				steps_q <= steps_q + SCW'(1);
				cur_q   <= NIW'(step_par);
				done_q  <= walk_end;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = state_q != W_IDLE;
	assign rsp.sum  = sum_q;

endmodule

`default_nettype wire

// File: tb/sv/graph_dfs_path_distance_tb.sv
// ----------------------------------------------------------------------------
// graph_dfs_path_distance_tb
// Self-checking bench for the edge loader and depth-first search block. A
// behavioral copy of the graph predicts every push, pop and summary transfer.
// It runs directed graphs first, then random graphs under varying input gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_dfs_path_distance_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gdpd_pkg::*;

	localparam int NODES = 16;
	localparam int EDGES = 32;

	// Command code that the block ignores.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	out_item_t result;
	logic result_strobe;

	graph_dfs_path_distance #(
		.NODES(NODES),
		.EDGES(EDGES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.result_strobe(result_strobe)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the graph held by the block.
	logic [NODE_W-1:0] edge_list_src [EDGES];
	logic [NODE_W-1:0] edge_list_dst [EDGES];
	int                edge_total;
	logic [NODE_W-1:0] parent_node [NODES];
	logic [DIST_W-1:0] parent_dist [NODES];

	out_item_t pending_events[$];
	int        fail_count = 0;
	int        sender_idle_pct = 0;

	// Queue one expected result transfer.
	function automatic void expect_event(logic [EV_W-1:0] ev, logic [NODE_W-1:0] nd,
			logic fd, logic [SUM_W-1:0] tot_dist, logic lst);
		out_item_t ev_item;
		ev_item.event_res = ev;
		ev_item.node = nd;
		ev_item.found = fd;
		ev_item.total_distance = tot_dist;
		ev_item.last = lst;
		pending_events.insert(pending_events.size(), ev_item);
	endfunction

	// Walk the search from node 0 and then sum the parent chain of the target.
	function automatic void predict_search(logic [NODE_W-1:0] target);
		bit                visited [NODES];
		logic [NODE_W-1:0] stack [NODES];
		int                depth;
		logic [NODE_W-1:0] top;
		logic [NODE_W-1:0] cur;
		bit                hit;
		bit                done;
		int                sum;
		foreach (visited[n])
			visited[n] = 1'b0;
		visited[0] = 1'b1;
		stack[0] = '0;
		depth = 1;
		hit = 1'b0;
		done = 1'b0;
		expect_event(EV_PUSH, '0, 1'b0, '0, 1'b0);
		while (!done) begin
			if (depth == 0) begin
				done = 1'b1;
			end else begin
				top = stack[depth-1];
				if (top == target) begin
					hit = 1'b1;
					done = 1'b1;
				end else begin
					depth--;
					expect_event(EV_POP, top, 1'b0, '0, 1'b0);
					for (int e = 0; e < edge_total; e++) begin
						if (edge_list_src[e] == top && !visited[edge_list_dst[e]] &&
								depth < NODES) begin
							visited[edge_list_dst[e]] = 1'b1;
							stack[depth] = edge_list_dst[e];
							depth++;
							expect_event(EV_PUSH, edge_list_dst[e], 1'b0, '0, 1'b0);
						end
					end
				end
			end
		end
		// The chain walk stops on reaching the root or after NODES steps.
		sum = 0;
		cur = target;
		for (int s = 0; s < NODES; s++) begin
			sum += parent_dist[cur];
			if (sum > int'(SUM_MAX))
				sum = int'(SUM_MAX);
			cur = parent_node[cur];
			if (cur == 0)
				break;
		end
		expect_event(EV_SUMMARY, target, hit, sum[SUM_W-1:0], 1'b1);
	endfunction

	// Update the shadow graph for one accepted command.
	function automatic void predict_command(in_item_t it);
		case (it.command)
			CMD_CLEAR: begin
				edge_total = 0;
				foreach (parent_node[n]) begin
					parent_node[n] = '0;
					parent_dist[n] = '0;
				end
			end
			CMD_ADD: begin
				// A full edge list drops the edge whole.
				if (edge_total < EDGES) begin
					edge_list_src[edge_total] = it.edge_source;
					edge_list_dst[edge_total] = it.edge_dest;
					edge_total++;
					parent_node[it.edge_dest] = it.edge_source;
					parent_dist[it.edge_dest] = it.edge_distance;
				end
			end
			CMD_SEARCH: predict_search(it.target_node);
			default: ;
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.command = CMD_W'($urandom_range(0, 3));
		it.edge_source = NODE_W'($urandom_range(0, NODES-1));
		it.edge_dest = NODE_W'($urandom_range(0, NODES-1));
		it.edge_distance = DIST_W'($urandom);
		it.target_node = NODE_W'($urandom_range(0, NODES-1));
		return it;
	endfunction

	// Offer one command and hold it until the block takes the transfer.
	task automatic send_item(in_item_t it);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			item <= random_item();
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predict_command(it);
	endtask

	task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] src,
			logic [NODE_W-1:0] dst, logic [DIST_W-1:0] edge_dist, logic [NODE_W-1:0] target);
		in_item_t it;
		it.command = cmd;
		it.edge_source = src;
		it.edge_dest = dst;
		it.edge_distance = edge_dist;
		it.target_node = target;
		send_item(it);
	endtask

	// Searches on the empty graph left by reset, and an unknown command.
	task automatic test_reset_state();
		send_cmd(CMD_SEARCH, 4'd3, 4'd9, 16'hA5A5, 4'd0);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd7);
		send_cmd(CMD_UNUSED, 4'd15, 4'd15, 16'hFFFF, 4'd15);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd15);
	endtask

	// Hand-built graphs: parent overwrite, self loop, an edge into the root,
	// an unreachable target and a parent cycle that runs the walk to its bound.
	task automatic test_directed_graphs();
		send_cmd(CMD_CLEAR, 4'd0, 4'd0, 16'h0000, 4'd0);
		send_cmd(CMD_ADD, 4'd0, 4'd1, 16'hFFFF, 4'd0);
		send_cmd(CMD_ADD, 4'd1, 4'd15, 16'h0000, 4'd15);
		send_cmd(CMD_ADD, 4'd15, 4'd15, 16'h0001, 4'd0);
		send_cmd(CMD_ADD, 4'd0, 4'd2, 16'h000A, 4'd0);
		send_cmd(CMD_ADD, 4'd2, 4'd1, 16'h0014, 4'd0);
		send_cmd(CMD_ADD, 4'd15, 4'd0, 16'h0005, 4'd0);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd15);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd0);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd2);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd14);
		send_cmd(CMD_CLEAR, 4'd15, 4'd15, 16'hFFFF, 4'd15);
		send_cmd(CMD_ADD, 4'd3, 4'd4, 16'hFFFF, 4'd0);
		send_cmd(CMD_ADD, 4'd4, 4'd3, 16'hFFFF, 4'd0);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd4);
		send_cmd(CMD_UNUSED, 4'd0, 4'd0, 16'h0000, 4'd0);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd3);
	endtask

	// Fill the edge list, then offer an edge from the root and an edge out of node 9, both of which must be dropped.
	task automatic test_edge_overflow();
		send_cmd(CMD_CLEAR, 4'd0, 4'd0, 16'h0000, 4'd0);
		for (int e = 0; e < EDGES; e++)
			send_cmd(CMD_ADD, e[3:0], e[3:0] + 4'd1, DIST_W'(e * 100 + 7), 4'd0);
		send_cmd(CMD_ADD, 4'd0, 4'd9, 16'hFFFF, 4'd0);
		send_cmd(CMD_ADD, 4'd9, 4'd3, 16'h1234, 4'd0);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd9);
		send_cmd(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd15);
	endtask

	// Mostly clear / load / search sequences over a random node span, with
	// some random commands mixed in.
	task automatic test_random_graphs(int idle_pct, int item_budget);
		int sent;
		int span;
		in_item_t it;
		sent = 0;
		sender_idle_pct = idle_pct;
		while (sent < item_budget) begin
			if ($urandom_range(99) < 80) begin
				it = random_item();
				it.command = CMD_CLEAR;
				send_item(it);
				span = $urandom_range(3, NODES-1);
				repeat ($urandom_range(1, 12)) begin
					it = random_item();
					it.command = CMD_ADD;
					it.edge_source = ($urandom_range(3) == 0) ? '0 : NODE_W'($urandom_range(0, span));
					it.edge_dest = NODE_W'($urandom_range(0, span));
					send_item(it);
					sent++;
				end
				repeat ($urandom_range(1, 3)) begin
					it = random_item();
					it.command = CMD_SEARCH;
					it.target_node = NODE_W'($urandom_range(0, span));
					send_item(it);
					sent++;
				end
				sent++;
			end else begin
				it = random_item();
				send_item(it);
				sent++;
			end
		end
	endtask

	// Compare each result transfer with the oldest expectation.
	out_item_t want;
	always @(posedge clk) begin
		if (arst_n && result_strobe === 1'b1) begin
			if (pending_events.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected result: event %0d node %0d found %0b dist %0d last %0b",
						result.event_res, result.node, result.found,
						result.total_distance, result.last);
			end else begin
				want = pending_events.pop_front();
				if (result.event_res !== want.event_res || result.node !== want.node ||
						result.found !== want.found ||
						result.total_distance !== want.total_distance ||
						result.last !== want.last) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("Mismatch: expected event %0d node %0d found %0b dist %0d last %0b",
							want.event_res, want.node, want.found, want.total_distance,
							want.last);
						$display("          got event %0d node %0d found %0b dist %0d last %0b",
							result.event_res, result.node, result.found,
							result.total_distance, result.last);
					end
				end
			end
		end
	end

	// Main sequence.
	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		edge_total = 0;
		foreach (parent_node[n]) begin
			parent_node[n] = '0;
			parent_dist[n] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_graphs();
		test_edge_overflow();
		test_random_graphs(28, 12);
		test_random_graphs(54, 12);
		test_random_graphs(0, 12);
		start <= 1'b0;

		// Drain the remaining results, then allow for trailing activity.
		for (wait_cycles = 0; pending_events.size() != 0 && wait_cycles < 5000; wait_cycles++)
			@(posedge clk);
		repeat (64) @(posedge clk);
		fail_count += pending_events.size();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
